>>> rtl/clr_pkg.sv
// Shared types and constants of the clipped line rasterizer.
// Used by clr_setup, clr_walker and clipped_line_rasterizer; no dependencies.
package clr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int COLOR_W        = 24;
    localparam int FRAME_W        = 13;
    localparam int CFG_IDX_W      = 1;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] finish_x;
        logic signed [FIELD_W-1:0] finish_y;
        logic [COLOR_W-1:0]        color;
    } t_item;

    typedef struct packed {
        logic                      valid_res;
        logic signed [FIELD_W-1:0] pixel_x;
        logic signed [FIELD_W-1:0] pixel_y;
        logic                      visible;
        logic                      last;
        logic [COLOR_W-1:0]        pixel_color;
    } t_pixel;

    typedef struct packed {
        logic adv;
        logic is_step;
    } t_walk_ctl;

endpackage

>>> rtl/clr_setup.sv
// Line setup: coordinate wrap, trivial clip reject, spans, directions, initial error.
// Depends on clr_pkg.
module clr_setup #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
    input  clr_pkg::t_item                  i_item,
    input  logic [clr_pkg::FRAME_W-1:0]     i_frame_width,
    input  logic [clr_pkg::FRAME_W-1:0]     i_frame_height,
    output logic                            o_reject,
    output logic signed [COORD_BITS-1:0]    o_x0,
    output logic signed [COORD_BITS-1:0]    o_y0,
    output logic signed [COORD_BITS-1:0]    o_x1,
    output logic signed [COORD_BITS-1:0]    o_y1,
    output logic signed [COORD_BITS:0]      o_dx,
    output logic signed [COORD_BITS:0]      o_dy,
    output logic                            o_x_neg,
    output logic                            o_y_neg,
    output logic signed [COORD_BITS+1:0]    o_err
);
    import clr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int CMPW = ((CB > FRAME_W) ? CB : FRAME_W) + 1;

    logic signed [CMPW-1:0] w_w;
    logic signed [CMPW-1:0] w_h;
    logic signed [CB:0]     w_diff_x;
    logic signed [CB:0]     w_diff_y;
    logic                   w_left;
    logic                   w_right;
    logic                   w_top;
    logic                   w_bottom;

    assign o_x0 = CB'(i_item.start_x);
    assign o_y0 = CB'(i_item.start_y);
    assign o_x1 = CB'(i_item.finish_x);
    assign o_y1 = CB'(i_item.finish_y);

    assign w_w = $signed(CMPW'({1'b0, i_frame_width}));
    assign w_h = $signed(CMPW'({1'b0, i_frame_height}));

    assign w_left   = o_x0[CB-1] && o_x1[CB-1];
    assign w_top    = o_y0[CB-1] && o_y1[CB-1];
    assign w_right  = (CMPW'(o_x0) >= w_w) && (CMPW'(o_x1) >= w_w);
    assign w_bottom = (CMPW'(o_y0) >= w_h) && (CMPW'(o_y1) >= w_h);
    assign o_reject = w_left || w_right || w_top || w_bottom;

    assign w_diff_x = (CB+1)'(o_x1) - (CB+1)'(o_x0);
    assign w_diff_y = (CB+1)'(o_y1) - (CB+1)'(o_y0);
    assign o_dx     = w_diff_x[CB] ? -w_diff_x : w_diff_x;
    assign o_dy     = w_diff_y[CB] ? -w_diff_y : w_diff_y;
    assign o_x_neg  = !(w_diff_x > 0);
    assign o_y_neg  = !(w_diff_y > 0);
    assign o_err    = (CB+2)'(o_dx) - (CB+2)'(o_dy);

endmodule

>>> rtl/clr_walker.sv
// Bresenham walker state, per-step pixel evaluation and the result register.
// Depends on clr_pkg.
module clr_walker #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  clr_pkg::t_walk_ctl              i_ctl,
    input  logic [clr_pkg::COLOR_W-1:0]     i_color,
    input  logic                            i_reject,
    input  logic signed [COORD_BITS-1:0]    i_x0,
    input  logic signed [COORD_BITS-1:0]    i_y0,
    input  logic signed [COORD_BITS-1:0]    i_x1,
    input  logic signed [COORD_BITS-1:0]    i_y1,
    input  logic signed [COORD_BITS:0]      i_dx,
    input  logic signed [COORD_BITS:0]      i_dy,
    input  logic                            i_x_neg,
    input  logic                            i_y_neg,
    input  logic signed [COORD_BITS+1:0]    i_err,
    input  logic [clr_pkg::FRAME_W-1:0]     i_frame_width,
    input  logic [clr_pkg::FRAME_W-1:0]     i_frame_height,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output clr_pkg::t_pixel                 o_out_data
);
    import clr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 2;
    localparam int CMPW = ((CB > FRAME_W) ? CB : FRAME_W) + 1;

    logic signed [CB-1:0]   r_cur_x;
    logic signed [CB-1:0]   r_cur_y;
    logic signed [CB-1:0]   r_end_x;
    logic signed [CB-1:0]   r_end_y;
    logic signed [CB:0]     r_dx;
    logic signed [CB:0]     r_dy;
    logic                   r_x_neg;
    logic                   r_y_neg;
    logic signed [EW-1:0]   r_err;
    logic                   r_active;
    logic [COLOR_W-1:0]     r_color;
    logic                   r_out_valid;
    t_pixel                 r_out;

    logic signed [CB-1:0]   n_cur_x;
    logic signed [CB-1:0]   n_cur_y;
    logic signed [EW-1:0]   n_err;
    t_pixel                 n_out;

    logic signed [EW:0]     w_e2;
    logic                   w_go_x;
    logic                   w_go_y;
    logic                   w_fin;
    logic                   w_vis;
    logic signed [CMPW-1:0] w_w;
    logic signed [CMPW-1:0] w_h;

    assign w_w    = $signed(CMPW'({1'b0, i_frame_width}));
    assign w_h    = $signed(CMPW'({1'b0, i_frame_height}));
    assign w_vis  = !r_cur_x[CB-1] && (CMPW'(r_cur_x) < w_w)
                 && !r_cur_y[CB-1] && (CMPW'(r_cur_y) < w_h);
    assign w_fin  = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);

    assign w_e2   = $signed({r_err, 1'b0});
    assign w_go_x = w_e2 > -((EW+1)'(r_dy));
    assign w_go_y = w_e2 < (EW+1)'(r_dx);

    always_comb begin
        n_err   = r_err;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (w_go_x) begin
            n_err   = n_err - EW'(r_dy);
            n_cur_x = r_x_neg ? r_cur_x - CB'(1) : r_cur_x + CB'(1);
        end
        if (w_go_y) begin
            n_err   = n_err + EW'(r_dx);
            n_cur_y = r_y_neg ? r_cur_y - CB'(1) : r_cur_y + CB'(1);
        end
    end

    always_comb begin
        n_out = '0;
        if (r_active) begin
            n_out.valid_res   = 1'b1;
            n_out.pixel_x     = FIELD_W'(r_cur_x);
            n_out.pixel_y     = FIELD_W'(r_cur_y);
            n_out.visible     = w_vis;
            n_out.last        = w_fin;
            n_out.pixel_color = r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.adv && !i_ctl.is_step) begin
                r_active <= !i_reject;
            end else if (i_ctl.adv && r_active && w_fin) begin
                r_active <= 1'b0;
            end
            if (i_ctl.adv && i_ctl.is_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && !i_ctl.is_step) begin
            r_cur_x <= i_x0;
            r_cur_y <= i_y0;
            r_end_x <= i_x1;
            r_end_y <= i_y1;
            r_dx    <= i_dx;
            r_dy    <= i_dy;
            r_x_neg <= i_x_neg;
            r_y_neg <= i_y_neg;
            r_err   <= i_err;
            r_color <= i_color;
        end else if (i_ctl.adv && r_active && !w_fin) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (i_ctl.adv && i_ctl.is_step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/clipped_line_rasterizer.sv
// Clipped Bresenham line rasterizer, top level: item register, frame size registers,
// setup and walker. Depends on clr_pkg, clr_setup and clr_walker.
//
// Usage:
//   Items arrive on the i_item_valid / o_item_ready channel. A start item loads
//   two endpoints and a color; a line with both endpoints past the same frame
//   edge is dropped and the walker stays idle. Every step item yields exactly one
//   result on o_out_valid / i_out_ready: the current pixel with visible and last
//   flags, or an all-zero result with valid_res low when no line is active.
//   A start item yields no result.
//   A step item's result passes through the item register, then the result
//   register. Throughput: one item per cycle while no step item waits on a stalled
//   result; the Bresenham update is a single add and compare pass.
//   Receiver stall: the result register holds; start items still drain, a step
//   item waits in the item register and ready drops.
//   Reset: walker idle, no result pending, frame size 640 by 480.
//   Frame size writes on i_cfg_we take effect at once; write only while idle.
module clipped_line_rasterizer #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    output logic                            o_item_ready,
    input  clr_pkg::t_item                  i_item_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output clr_pkg::t_pixel                 o_out_data,
    input  logic                            i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clr_pkg::FRAME_W-1:0]     i_cfg_data
);
    import clr_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 r_in_valid;
    t_item                r_in;
    logic [FRAME_W-1:0]   r_frame_width;
    logic [FRAME_W-1:0]   r_frame_height;

    t_walk_ctl            w_ctl;
    logic                 w_adv;
    logic                 w_is_step;
    logic                 w_res_free;
    logic                 w_reject;
    logic signed [CB-1:0] w_x0;
    logic signed [CB-1:0] w_y0;
    logic signed [CB-1:0] w_x1;
    logic signed [CB-1:0] w_y1;
    logic signed [CB:0]   w_dx;
    logic signed [CB:0]   w_dy;
    logic                 w_x_neg;
    logic                 w_y_neg;
    logic signed [CB+1:0] w_err;

    assign w_is_step    = (r_in.op == OP_STEP);
    assign w_res_free   = !o_out_valid || i_out_ready;
    assign w_adv        = r_in_valid && (!w_is_step || w_res_free);
    assign o_item_ready = !r_in_valid || w_adv;
    assign w_ctl.adv     = w_adv;
    assign w_ctl.is_step = w_is_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else begin
            if (o_item_ready) begin
                r_in_valid <= i_item_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_in <= i_item_data;
        end
    end

    clr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_item         (r_in),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_reject       (w_reject),
        .o_x0           (w_x0),
        .o_y0           (w_y0),
        .o_x1           (w_x1),
        .o_y1           (w_y1),
        .o_dx           (w_dx),
        .o_dy           (w_dy),
        .o_x_neg        (w_x_neg),
        .o_y_neg        (w_y_neg),
        .o_err          (w_err)
    );

    clr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_color        (r_in.color),
        .i_reject       (w_reject),
        .i_x0           (w_x0),
        .i_y0           (w_y0),
        .i_x1           (w_x1),
        .i_y1           (w_y1),
        .i_dx           (w_dx),
        .i_dy           (w_dy),
        .i_x_neg        (w_x_neg),
        .i_y_neg        (w_y_neg),
        .i_err          (w_err),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_item_ready) |-> (w_is_step && o_out_valid && !i_out_ready))
        else $error("item stalled without a blocked step result");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_adv && w_is_step))
        else $error("result appeared without a step transfer");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.valid_res) |->
            (!o_out_data.visible && !o_out_data.last && o_out_data.pixel_color == '0))
        else $error("idle result carries pixel data");

endmodule
